@@ hw/rtl/nts_pkg.sv @@
// Shared request, status and width constants for the nearest timestamp search block.
`default_nettype none
package nts_pkg;

  localparam int unsigned StampW = 64;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned OutIdxW = 10;

  localparam logic [ReqW-1:0] REQ_APPEND = 2'd0;
  localparam logic [ReqW-1:0] REQ_QUERY  = 2'd1;
  localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd2;

  localparam logic [StampW-1:0] SignBit = {1'b1, {(StampW-1){1'b0}}};

endpackage
`default_nettype wire

@@ hw/rtl/nearest_timestamp_binary_search_top.sv @@
// Top level: timestamp table with append, clear and binary nearest-value query.
//
// Input channel s_axis: tuser carries the request kind (append, query, clear),
// tdata the signed 64-bit timestamp. Output channel m_axis: tuser carries the
// status (ok, empty table, full table), tdata the 10-bit entry index.
// Every input transaction yields exactly one output transaction.
//
// One request is processed at a time. Append, clear, unused codes and a
// query on an empty table go from acceptance straight to ST_FIN. Any other
// query passes ST_INIT and then P probes, where P is at most
// floor(log2(count))+1, 11 for 1024 entries. Each probe is one read of the
// single-port table RAM in ST_PROBE and a compare on the read data in ST_CMP.
//
// The next request is accepted as soon as the previous one has been handed
// to the output register, even while that result still waits for m_axis
// ready. If the receiver stalls, a finished result waits in its own stage
// until the output register frees up.
//
// Reset clears the entry count, so the table is empty; table RAM contents
// are not reset and are only read below the entry count.
`default_nettype none
module nearest_timestamp_binary_search_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [63:0] stamp
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [9:0] found_index, [15:10] zero
  output logic [1:0]       m_axis_tuser   // [1:0] status
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW   = nts_pkg::StampW;
  localparam int unsigned OW   = nts_pkg::OutIdxW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] hi1_q, hi1_d;
  logic [CntW-1:0] mid_q, mid_d;
  logic [IdxW-1:0] best_q, best_d;
  logic [SW-1:0]   best_key_q, best_key_d;
  logic [SW-1:0]   best_diff_q, best_diff_d;
  logic [SW-1:0]   tgt_key_q, tgt_key_d;
  logic [nts_pkg::StatW-1:0] res_stat_q, res_stat_d;
  logic [OW-1:0]   res_idx_q, res_idx_d;

  logic                      out_valid_q, out_valid_d;
  logic [nts_pkg::StatW-1:0] out_stat_q, out_stat_d;
  logic [OW-1:0]             out_idx_q, out_idx_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [SW-1:0]   ram_rdata;

  logic            in_acc;
  logic [SW-1:0]   cur_key, diff_fwd, diff_rev, cur_diff;
  logic [CntW-1:0] mid_calc;
  logic [IdxW+OW-1:0] cnt_ext, mid_ext, best_ext;

  nts_ram #(
    .Width(SW),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(s_axis_tdata),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign cur_key  = ram_rdata ^ nts_pkg::SignBit;
  assign diff_fwd = cur_key - tgt_key_q;
  assign diff_rev = tgt_key_q - cur_key;
  assign cur_diff = (cur_key >= tgt_key_q) ? diff_fwd : diff_rev;
  assign mid_calc = lo_q + ((hi1_q - lo_q - CntW'(1)) >> 1);

  assign cnt_ext  = {{OW{1'b0}}, cnt_q[IdxW-1:0]};
  assign mid_ext  = {{OW{1'b0}}, mid_q[IdxW-1:0]};
  assign best_ext = {{OW{1'b0}}, best_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi1_d       = hi1_q;
    mid_d       = mid_q;
    best_d      = best_q;
    best_key_d  = best_key_q;
    best_diff_d = best_diff_q;
    tgt_key_d   = tgt_key_q;
    res_stat_d  = res_stat_q;
    res_idx_d   = res_idx_q;
    ram_we      = 1'b0;
    ram_addr    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_stat_d = nts_pkg::STAT_OK;
          res_idx_d  = '0;
          state_d    = ST_FIN;
          case (s_axis_tuser)
            nts_pkg::REQ_APPEND: begin
              if (cnt_q < CntW'(TABLE_DEPTH)) begin
                ram_we    = 1'b1;
                ram_addr  = cnt_q[IdxW-1:0];
                res_idx_d = cnt_ext[OW-1:0];
                cnt_d     = cnt_q + CntW'(1);
              end else begin
                res_stat_d = nts_pkg::STAT_FULL;
              end
            end
            nts_pkg::REQ_QUERY: begin
              tgt_key_d = s_axis_tdata ^ nts_pkg::SignBit;
              if (cnt_q == '0) begin
                res_stat_d = nts_pkg::STAT_EMPTY;
              end else begin
                ram_addr = '0;
                state_d  = ST_INIT;
              end
            end
            nts_pkg::REQ_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_INIT: begin
        best_d      = '0;
        best_key_d  = cur_key;
        best_diff_d = cur_diff;
        lo_d        = '0;
        hi1_d       = cnt_q;
        state_d     = ST_PROBE;
      end
      ST_PROBE: begin
        if (lo_q < hi1_q) begin
          mid_d    = mid_calc;
          ram_addr = mid_calc[IdxW-1:0];
          state_d  = ST_CMP;
        end else begin
          res_idx_d = best_ext[OW-1:0];
          state_d   = ST_FIN;
        end
      end
      ST_CMP: begin
        if (cur_diff < best_diff_q) begin
          best_diff_d = cur_diff;
          best_key_d  = cur_key;
          best_d      = mid_q[IdxW-1:0];
        end else if (cur_diff == best_diff_q && cur_key > best_key_q) begin
          best_key_d = cur_key;
          best_d     = mid_q[IdxW-1:0];
        end
        if (cur_key == tgt_key_q) begin
          res_idx_d = mid_ext[OW-1:0];
          state_d   = ST_FIN;
        end else begin
          if (cur_key > tgt_key_q) begin
            lo_d = mid_q + CntW'(1);
          end else begin
            hi1_d = mid_q;
          end
          state_d = ST_PROBE;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_stat_d  = out_stat_q;
    out_idx_d   = out_idx_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
      out_valid_d = 1'b1;
      out_stat_d  = res_stat_q;
      out_idx_d   = res_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi1_q       <= hi1_d;
    mid_q       <= mid_d;
    best_q      <= best_d;
    best_key_q  <= best_key_d;
    best_diff_q <= best_diff_d;
    tgt_key_q   <= tgt_key_d;
    res_stat_q  <= res_stat_d;
    res_idx_q   <= res_idx_d;
    out_stat_q  <= out_stat_d;
    out_idx_q   <= out_idx_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {{(16 - OW){1'b0}}, out_idx_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (mid_q < cnt_q && hi1_q <= cnt_q))
    else $error("probe index outside filled entries");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("new request accepted while previous one in flight");

  a_fin_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) |=>
      (m_axis_tvalid && m_axis_tuser == $past(res_stat_q)))
    else $error("finished result not moved to output register");

endmodule
`default_nettype wire

@@ hw/rtl/nts_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module nts_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
